/* src/rppi_pkg.sv */
// Shared types, constants and tables for the regular polygon point test.
`timescale 1ns / 1ps
`default_nettype none
package rppi_pkg;

   localparam int CORDIC_STAGES = 20;
   localparam int FRACTION_BITS = 16;
   localparam int MAX_EDGES     = 64;

   localparam int COORD_W  = 32;
   localparam int ANGLE_W  = 32;
   localparam int DATA_W   = 36;
   localparam int EDGE_W   = 7;
   localparam int RADIUS_W = 31;
   localparam int ROT_W    = 16;
   localparam int STAGE_W  = 5;

   localparam logic signed [DATA_W-1:0] CORDIC_START =
      DATA_W'(652032874 >> (30 - FRACTION_BITS));

   typedef enum logic [1:0] {
      CSR_CORNER_RADIUS  = 2'd0,
      CSR_EDGE_COUNT     = 2'd1,
      CSR_ROTATION_TURNS = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SQUARE, ST_RANGE, ST_VECTOR, ST_SECTOR,
      ST_DSTART0, ST_DIV0, ST_DSTART1, ST_DIV1,
      ST_INJECT0, ST_INJECT1, ST_ROTATE, ST_SCALE, ST_SATURATE,
      ST_PRODUCT, ST_CROSS, ST_OUT
   } state_type;

   typedef struct packed {
      logic                     valid;
      logic                     vec_mode;
      logic                     tag;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic [ANGLE_W-1:0]       z;
   } cordic_beat_type;

   function automatic logic [ANGLE_W-1:0] atan_turns(input logic [STAGE_W-1:0] idx);
      logic [ANGLE_W-1:0] r;
      unique case (idx)
         5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2F9;  5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/regular_polygon_point_inside_core.sv */
// Top level: point inside a rotated regular polygon centred at the origin.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  req_point_x, req_point_y
//  rsp      out        rsp_valid/rsp_ready  rsp_is_inside
//  csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One request at a time. A point beyond the corner radius is answered straight from
// the range check; any other point takes two passes through the 20-cell CORDIC row
// (vectoring, then both corners back to back), two sector divisions and the scale,
// saturate, product and cross stages.
// Reset is synchronous and restores radius 1.0, a three-sided polygon and no rotation.
// A stalled response holds the block; csr writes are taken in every cycle.
`timescale 1ns / 1ps
`default_nettype none
module regular_polygon_point_inside_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [rppi_pkg::COORD_W-1:0] req_point_x,
   input  wire logic signed [rppi_pkg::COORD_W-1:0] req_point_y,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_is_inside,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [31:0]                   csr_wdata
);
   import rppi_pkg::*;

   state_type state_ff, state_in;

   logic [RADIUS_W-1:0] radius_ff;
   logic [EDGE_W-1:0]   edges_ff, n_eff;
   logic [ROT_W-1:0]    rot_ff;
   logic [ANGLE_W-1:0]  rot32;

   logic signed [COORD_W-1:0] px_ff, py_ff;
   logic [63:0] xx_ff, yy_ff, r2_ff;
   logic [ANGLE_W-1:0] rel_ff, q0_ff, q1_ff, a0, a1;
   logic [EDGE_W-1:0]  sector_ff;
   logic [EDGE_W+ANGLE_W-1:0] sec_prod;
   logic flip0_ff, flip1_ff;
   logic signed [19:0] cx0_ff, cy0_ff, cx1_ff, cy1_ff;
   logic signed [51:0] mx0_ff, my0_ff, mx1_ff, my1_ff;
   logic signed [33:0] da_ff, db_ff, dc_ff, dd_ff;
   logic signed [52:0] ph_ff, pl_ff;
   logic inside_ff, inside_in;
   logic outside;
   logic signed [DATA_W-1:0] px36, py36, cap_x, cap_y;
   logic signed [COORD_W-1:0] sx0, sy0, sx1, sy1;
   logic signed [71:0] cross_sum;

   cordic_beat_type chain_in, chain_out;
   logic div_start, div_done;
   logic [EDGE_W-1:0] div_k;
   logic [ANGLE_W-1:0] div_q;

   rppi_cordic_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .beat_in (chain_in),
      .beat_out(chain_out)
   );

   rppi_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .numer_k (div_k),
      .denom_n (n_eff),
      .done    (div_done),
      .quotient(div_q)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_W'(65536);
         edges_ff  <= EDGE_W'(3);
         rot_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_CORNER_RADIUS:  radius_ff <= csr_wdata[RADIUS_W-1:0];
            CSR_EDGE_COUNT:     edges_ff  <= csr_wdata[EDGE_W-1:0];
            CSR_ROTATION_TURNS: rot_ff    <= csr_wdata[ROT_W-1:0];
            CSR_UNUSED:         ;
         endcase
      end
   end

   function automatic logic signed [COORD_W-1:0] scale_sat(input logic signed [51:0] p);
      logic signed [51:0] s;
      s = p >>> FRACTION_BITS;
      if (s > 52'sd2147483647) return 32'sh7FFFFFFF;
      if (s < -52'sd2147483648) return 32'sh80000000;
      return s[COORD_W-1:0];
   endfunction

   always_comb begin
      if (edges_ff < EDGE_W'(3)) n_eff = EDGE_W'(3);
      else if (edges_ff > EDGE_W'(MAX_EDGES)) n_eff = EDGE_W'(MAX_EDGES);
      else n_eff = edges_ff;
      rot32    = {rot_ff, {(ANGLE_W-ROT_W){1'b0}}};
      outside  = (xx_ff + yy_ff) > r2_ff;
      px36     = DATA_W'(px_ff);
      py36     = DATA_W'(py_ff);
      sec_prod = {{EDGE_W{1'b0}}, rel_ff} * {{ANGLE_W{1'b0}}, n_eff};
      a0       = rot32 + q0_ff;
      a1       = rot32 + q1_ff;
      cap_x    = (chain_out.tag ? flip1_ff : flip0_ff) ? -chain_out.x : chain_out.x;
      cap_y    = (chain_out.tag ? flip1_ff : flip0_ff) ? -chain_out.y : chain_out.y;
      sx0      = scale_sat(mx0_ff);
      sy0      = scale_sat(my0_ff);
      sx1      = scale_sat(mx1_ff);
      sy1      = scale_sat(my1_ff);
      cross_sum = (72'(ph_ff) <<< 17) + 72'(pl_ff);
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      div_start = 1'b0;
      div_k     = sector_ff;
      inside_in = inside_ff;
      chain_in  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) state_in = ST_SQUARE;
         end
         ST_SQUARE: state_in = ST_RANGE;
         ST_RANGE: begin
            if (outside) begin
               inside_in = 1'b0;
               state_in  = ST_OUT;
            end else begin
               // fold the left half plane onto the right
               chain_in.valid    = 1'b1;
               chain_in.vec_mode = 1'b1;
               chain_in.x = px_ff[COORD_W-1] ? -px36 : px36;
               chain_in.y = px_ff[COORD_W-1] ? -py36 : py36;
               chain_in.z = px_ff[COORD_W-1] ? 32'h80000000 : '0;
               state_in   = ST_VECTOR;
            end
         end
         ST_VECTOR:  if (chain_out.valid) state_in = ST_SECTOR;
         ST_SECTOR:  state_in = ST_DSTART0;
         ST_DSTART0: begin
            div_start = 1'b1;
            state_in  = ST_DIV0;
         end
         ST_DIV0:    if (div_done) state_in = ST_DSTART1;
         ST_DSTART1: begin
            div_start = 1'b1;
            div_k     = sector_ff + 1'b1;
            state_in  = ST_DIV1;
         end
         ST_DIV1:    if (div_done) state_in = ST_INJECT0;
         ST_INJECT0: begin
            chain_in.valid = 1'b1;
            chain_in.tag   = 1'b0;
            chain_in.x     = CORDIC_START;
            chain_in.z     = {a0[31] ^ (a0[31] ^ a0[30]), a0[30:0]};
            state_in       = ST_INJECT1;
         end
         ST_INJECT1: begin
            chain_in.valid = 1'b1;
            chain_in.tag   = 1'b1;
            chain_in.x     = CORDIC_START;
            chain_in.z     = {a1[31] ^ (a1[31] ^ a1[30]), a1[30:0]};
            state_in       = ST_ROTATE;
         end
         ST_ROTATE:   if (chain_out.valid && chain_out.tag) state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_SATURATE;
         ST_SATURATE: state_in = ST_PRODUCT;
         ST_PRODUCT:  state_in = ST_CROSS;
         ST_CROSS: begin
            inside_in = cross_sum > 72'sd0;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      inside_ff <= inside_in;
      if (req_valid && req_ready) begin
         px_ff <= req_point_x;
         py_ff <= req_point_y;
      end
      xx_ff <= 64'(px_ff * px_ff);
      yy_ff <= 64'(py_ff * py_ff);
      r2_ff <= {33'b0, radius_ff} * {33'b0, radius_ff};
      if (state_ff == ST_VECTOR && chain_out.valid) rel_ff <= chain_out.z - rot32;
      if (state_ff == ST_SECTOR) sector_ff <= sec_prod[EDGE_W+ANGLE_W-1:ANGLE_W];
      if (state_ff == ST_DIV0 && div_done) q0_ff <= div_q;
      if (state_ff == ST_DIV1 && div_done) q1_ff <= div_q;
      // corners in the back half turn are rotated by half a turn and negated
      if (state_ff == ST_INJECT0) flip0_ff <= a0[31] ^ a0[30];
      if (state_ff == ST_INJECT1) flip1_ff <= a1[31] ^ a1[30];
      if (state_ff == ST_ROTATE && chain_out.valid) begin
         if (chain_out.tag) begin
            cx1_ff <= cap_x[19:0];
            cy1_ff <= cap_y[19:0];
         end else begin
            cx0_ff <= cap_x[19:0];
            cy0_ff <= cap_y[19:0];
         end
      end
      mx0_ff <= $signed({1'b0, radius_ff}) * cx0_ff;
      my0_ff <= $signed({1'b0, radius_ff}) * cy0_ff;
      mx1_ff <= $signed({1'b0, radius_ff}) * cx1_ff;
      my1_ff <= $signed({1'b0, radius_ff}) * cy1_ff;
      da_ff  <= 34'(py_ff) - 34'(sy0);
      db_ff  <= 34'(sx1) - 34'(sx0);
      dc_ff  <= 34'(px_ff) - 34'(sx0);
      dd_ff  <= 34'(sy1) - 34'(sy0);
      // exact cross sign from split 17-bit halves
      ph_ff  <= 53'(da_ff * 18'(db_ff >>> 17)) - 53'(dc_ff * 18'(dd_ff >>> 17));
      pl_ff  <= 53'(da_ff * $signed({1'b0, db_ff[16:0]}))
              - 53'(dc_ff * $signed({1'b0, dd_ff[16:0]}));
   end

   assign rsp_is_inside = inside_ff;

   a_chain_window: assert property (@(posedge clock) disable iff (reset)
      chain_out.valid |-> (state_ff == ST_VECTOR || state_ff == ST_ROTATE))
      else $error("CORDIC row output outside its window");
   a_div_window: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV0 || state_ff == ST_DIV1))
      else $error("divider finished while not awaited");
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_SQUARE)
      else $error("accepted request did not start");
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RANGE && outside) |=> (rsp_valid && !rsp_is_inside))
      else $error("point beyond radius not reported outside");
endmodule
`default_nettype wire

/* src/rppi_cordic_cell.sv */
// One CORDIC micro-rotation cell, shared by vectoring and rotation.
`timescale 1ns / 1ps
`default_nettype none
module rppi_cordic_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [rppi_pkg::STAGE_W-1:0] stage_idx,
   input  wire rppi_pkg::cordic_beat_type    beat_in,
   output rppi_pkg::cordic_beat_type         beat_out
);
   import rppi_pkg::*;

   cordic_beat_type beat_ff, beat_in_c;
   logic signed [DATA_W-1:0] xs, ys;
   logic [ANGLE_W-1:0] step;
   logic ccw;

   always_comb begin
      xs   = beat_in.x >>> stage_idx;
      ys   = beat_in.y >>> stage_idx;
      step = atan_turns(stage_idx);
      // vectoring drives y to zero, rotation drives z to zero
      ccw  = beat_in.vec_mode ? beat_in.y[DATA_W-1] : !beat_in.z[ANGLE_W-1];
      beat_in_c = beat_in;
      if (ccw) begin
         beat_in_c.x = beat_in.x - ys;
         beat_in_c.y = beat_in.y + xs;
         beat_in_c.z = beat_in.z - step;
      end else begin
         beat_in_c.x = beat_in.x + ys;
         beat_in_c.y = beat_in.y - xs;
         beat_in_c.z = beat_in.z + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else begin
         beat_ff <= beat_in_c;
      end
   end

   assign beat_out = beat_ff;
endmodule
`default_nettype wire

/* src/rppi_cordic_chain.sv */
// Row of CORDIC cells, one iteration per cell, one cell per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rppi_cordic_chain (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rppi_pkg::cordic_beat_type beat_in,
   output rppi_pkg::cordic_beat_type      beat_out
);
   import rppi_pkg::*;

   cordic_beat_type link [0:CORDIC_STAGES];

   assign link[0] = beat_in;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      rppi_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .stage_idx(STAGE_W'(g)),
         .beat_in  (link[g]),
         .beat_out (link[g+1])
      );
   end

   assign beat_out = link[CORDIC_STAGES];
endmodule
`default_nettype wire

/* src/rppi_divider.sv */
// Restoring divider: floor(k * 2^32 / n), one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rppi_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rppi_pkg::EDGE_W-1:0] numer_k,
   input  wire logic [rppi_pkg::EDGE_W-1:0] denom_n,
   output logic                             done,
   output logic [rppi_pkg::ANGLE_W-1:0]     quotient
);
   import rppi_pkg::*;

   localparam int NUM_W = EDGE_W + ANGLE_W;
   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [EDGE_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [ANGLE_W-1:0] quo_ff, quo_in;
   logic [EDGE_W:0]  trial;
   logic             ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, num_ff[NUM_W-1]};
      ge      = trial >= {1'b0, denom_n};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W - 1);
         rem_in  = '0;
         num_in  = {numer_k, {ANGLE_W{1'b0}}};
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? EDGE_W'(trial - {1'b0, denom_n}) : trial[EDGE_W-1:0];
         quo_in = {quo_ff[ANGLE_W-2:0], ge};
         num_in = num_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

/* sim/tb.sv */
// Self-checking bench for the regular polygon point test core.
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import rppi_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [COORD_W-1:0] req_point_x = '0;
   logic signed [COORD_W-1:0] req_point_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_is_inside;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // prediction copy of the registers
   logic [30:0] radius_q = 31'd65536;
   logic [6:0] edges_q = 7'd3;
   logic [15:0] rot_q = '0;

   bit inside_q[$];
   int fail_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_rsp = 1'b0;
   int quiet_cycles = 0;

   regular_polygon_point_inside_core i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint asr64(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic [31:0] angle_of(longint x, longint y);
      logic [31:0] z;
      longint nx, ny;
      z = '0;
      if (x < 0) begin
         x = -x; y = -y; z = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         if (y >= 0) begin
            nx = x + asr64(y, i); ny = y - asr64(x, i);
            z = z + atan_turns(STAGE_W'(i));
         end else begin
            nx = x - asr64(y, i); ny = y + asr64(x, i);
            z = z - atan_turns(STAGE_W'(i));
         end
         x = nx; y = ny;
      end
      return z;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic void corner_at(input logic [31:0] a, output longint cx,
                                     output longint cy);
      longint x, y, z, nx, ny;
      bit flip;
      x = 652032874 >> (30 - FRACTION_BITS);
      y = 0;
      flip = 1'b0;
      if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
         a = a - 32'h8000_0000; flip = 1'b1;
      end
      z = longint'(signed'(a));
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         if (z >= 0) begin
            nx = x - asr64(y, i); ny = y + asr64(x, i);
            z = z - atan_turns(STAGE_W'(i));
         end else begin
            nx = x + asr64(y, i); ny = y - asr64(x, i);
            z = z + atan_turns(STAGE_W'(i));
         end
         x = nx; y = ny;
      end
      if (flip) begin
         x = -x; y = -y;
      end
      cx = clamp32(asr64(longint'(radius_q) * x, FRACTION_BITS));
      cy = clamp32(asr64(longint'(radius_q) * y, FRACTION_BITS));
   endfunction

   function automatic bit point_inside(longint x, longint y);
      logic [63:0] dist2, rad2, n, sector;
      logic [31:0] rot, rel, a0, a1;
      longint x0, y0, x1, y1;
      logic signed [127:0] cross_val;
      dist2 = x * x + y * y;
      rad2 = 64'(radius_q) * 64'(radius_q);
      n = edges_q;
      if (n < 3) n = 3;
      if (n > MAX_EDGES) n = MAX_EDGES;
      if (dist2 > rad2) return 1'b0;
      rot = {rot_q, 16'h0};
      rel = angle_of(x, y) - rot;
      sector = (64'(rel) * n) >> 32;
      a0 = rot + 32'((sector << 32) / n);
      a1 = rot + 32'(((sector + 1) << 32) / n);
      corner_at(a0, x0, y0);
      corner_at(a1, x1, y1);
      cross_val = 128'(y - y0) * 128'(x1 - x0) - 128'(x - x0) * 128'(y1 - y0);
      return cross_val > 0;
   endfunction

   task automatic send_point(input logic [31:0] px, input logic [31:0] py);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      inside_q.push_back(point_inside(signed'(px), signed'(py)));
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (inside_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CORNER_RADIUS:  radius_q = value[30:0];
         CSR_EDGE_COUNT:     edges_q = value[6:0];
         CSR_ROTATION_TURNS: rot_q = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // random point, mostly within a few radii of the origin
   task automatic send_random();
      logic [31:0] px, py;
      int span;
      if ($urandom_range(9) == 0) begin
         px = $urandom; py = $urandom;
      end else begin
         span = (radius_q == 0) ? 1 : radius_q;
         px = $urandom_range(2 * span) - span;
         py = $urandom_range(2 * span) - span;
         if ($urandom_range(1)) begin
            px = px + px[31:1]; py = py + py[31:1];
         end
      end
      send_point(px, py);
   endtask

   task automatic test_directed();
      logic [31:0] ext[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                              32'h0001_0000, 32'hFFFF_0000};
      foreach (ext[i]) send_point(ext[i], ext[(i + 2) % 6]);
      send_point(32'h0, 32'h0);
      send_point(32'h0001_0000, 32'h0);   // on the corner circle
      send_point(32'h0000_8000, 32'h0);
      send_point(32'hFFFF_8001, 32'h0);
      send_point(32'h0, 32'h0000_7FFF);
      send_point(32'h0, 32'hFFFF_0000);
      drain();
      write_reg(CSR_CORNER_RADIUS, 32'h0);
      send_point(32'h0, 32'h0);           // zero radius gives outside
      send_point(32'h1, 32'h0);
      drain();
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      write_reg(CSR_EDGE_COUNT, 32'h0);   // below three acts as three
      write_reg(CSR_CORNER_RADIUS, 32'h7FFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h0);
      send_point(32'h8000_0000, 32'h8000_0000);
      send_point(32'h4000_0000, 32'hC000_0000);
      drain();
      write_reg(CSR_EDGE_COUNT, 32'h7F);  // above the maximum acts as the maximum
      write_reg(CSR_ROTATION_TURNS, 32'hFFFF);
      send_point(32'h7FFF_0000, 32'h0);
      send_point(32'h0, 32'h7FFF_0000);
      drain();
   endtask

   task automatic test_random_phase(input int s_pct, input int r_pct, input int count);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      write_reg(CSR_CORNER_RADIUS, ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h40000));
      write_reg(CSR_EDGE_COUNT, $urandom_range(3) == 0 ? $urandom_range(127) : $urandom_range(3, 12));
      write_reg(CSR_ROTATION_TURNS, $urandom);
      repeat (count) send_random();
      drain();
   endtask

   task automatic test_backpressure();
      write_reg(CSR_CORNER_RADIUS, 32'h0003_0000);
      write_reg(CSR_EDGE_COUNT, 32'd6);
      hold_rsp <= 1'b1;
      fork
         begin
            repeat (600) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         repeat (6) send_random();
      join
      drain();
   endtask

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (inside_q.size() == 0) begin
            $error("is_inside: unexpected response %0b", rsp_is_inside);
            fail_count++;
         end else if (inside_q[0] != rsp_is_inside) begin
            $error("is_inside: expected %0b actual %0b", inside_q[0], rsp_is_inside);
            fail_count++;
            void'(inside_q.pop_front());
         end else begin
            void'(inside_q.pop_front());
         end
      end
   end

   always @(posedge clock)
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);

   // stall watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("regular_polygon_point_inside_core: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      for (int k = 0; k < 4; k++) test_random_phase(18, 80, 80);
      for (int k = 0; k < 4; k++) test_random_phase(80, 18, 80);
      for (int k = 0; k < 5; k++) test_random_phase(0, 0, 70);
      if (fail_count == 0 && inside_q.size() == 0)
         $display("regular_polygon_point_inside_core: match");
      else
         $display("regular_polygon_point_inside_core: mismatch");
      $finish;
   end
endmodule
`default_nettype wire
